[sv/twma_pkg.sv]
// Shared types and constants for the triangle-weighted moving average.
// No dependencies; the top level, the cell and the divider refer to this package by scoped names.
package twma_pkg;

    localparam int SAMPLE_W = 24;

    // Input operation codes, carried in the input tuser bit.
    typedef enum logic {
        OP_ADD   = 1'b0,
        OP_RESET = 1'b1
    } t_op;

    // Per-cycle command for every cell of the sample chain.
    typedef struct packed {
        logic shift;
        logic clear;
    } t_cell_ctrl;

endpackage

[sv/triangle_weighted_moving_average.sv]
// Triangle-weighted moving average: top level with the sample chain,
// the running and weighted sums, and the output register.
// Depends on twma_pkg, twma_cell and twma_div.
//
// Each request carries an op in tuser (0 add the sample in tdata, 1 reset the
// filter keeping only the newest sample) and yields one result: the rounded
// weighted average (newest sample weight WINDOW_SIZE, oldest weight 1,
// divided by W = WINDOW_SIZE*(WINDOW_SIZE+1)/2 with W/2 added first and the
// quotient truncated toward zero), the newest raw sample, and a window-full
// flag in tuser. Until the window has filled once since reset, the filtered
// value equals the raw sample. The samples sit in a chain of cells that
// shifts by one on every add; the oldest sample falls off the far end. One
// request at a time: after the accepting edge the request passes a start
// state and the constant divider, which takes three register stages
// (magnitude, two half-width reciprocal products, sum and shift); its result
// enters the output register once the slot is free, and only then can the
// next request be accepted. A finished result waits in the output register
// while the next request is taken; if it still waits when the next quotient
// is ready, hold that request's result back until the output slot frees.
module triangle_weighted_moving_average #(
    parameter int WINDOW_SIZE = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [23:0] i_s_axis_tdata,   // [23:0] sample
    input  logic        i_s_axis_tuser,   // [0] op
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [47:0] o_m_axis_tdata,   // [23:0] filtered_value, [47:24] raw_value
    output logic        o_m_axis_tuser    // [0] window_full
);

    localparam int SW     = twma_pkg::SAMPLE_W;
    localparam int TOTAL  = WINDOW_SIZE * (WINDOW_SIZE + 1) / 2;
    localparam int SUM_W  = SW + $clog2(WINDOW_SIZE) + 1;
    localparam int WGT_W  = SW + $clog2(TOTAL) + 1;
    localparam int DVD_W  = WGT_W + 1;
    localparam int IDX_W  = (WINDOW_SIZE > 1) ? $clog2(WINDOW_SIZE) : 1;
    localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(WINDOW_SIZE - 1);
    localparam logic signed [WGT_W-1:0] N_WGT = WGT_W'(WINDOW_SIZE);
    localparam logic signed [DVD_W-1:0] HALF_W = DVD_W'(TOTAL / 2);

    typedef enum logic [2:0] {
        S_IDLE  = 3'b001,
        S_START = 3'b010,
        S_WAIT  = 3'b100
    } t_state;

    t_state r_state, n_state;

    // Sample chain
    logic signed [SW-1:0] w_cell [WINDOW_SIZE];
    logic signed [SW-1:0] w_head_in;
    twma_pkg::t_cell_ctrl w_head_ctrl, w_tail_ctrl;

    logic                    r_full, n_full;
    logic [IDX_W-1:0]        r_index, n_index;
    logic signed [SUM_W-1:0] r_running, n_running;
    logic signed [WGT_W-1:0] r_weighted, n_weighted;

    logic r_m_valid;
    logic [47:0] r_m_data;
    logic r_m_full;

    logic w_in_acc, w_is_reset, w_div_done, w_load;
    logic signed [SW-1:0]    w_new;
    logic signed [WGT_W-1:0] w_new_wgt;
    logic signed [DVD_W-1:0] w_dividend;
    logic signed [SW-1:0]    w_quotient;

    assign o_s_axis_tready = (r_state == S_IDLE);
    assign w_in_acc   = i_s_axis_tvalid && o_s_axis_tready;
    assign w_is_reset = (twma_pkg::t_op'(i_s_axis_tuser) == twma_pkg::OP_RESET);

    // On reset, re-insert the newest sample; on add, insert the new one.
    assign w_new     = w_is_reset ? w_cell[0] : $signed(i_s_axis_tdata);
    assign w_head_in = w_new;

    always_comb begin
        w_head_ctrl.shift = w_in_acc;
        w_head_ctrl.clear = 1'b0;
        w_tail_ctrl.shift = w_in_acc && !w_is_reset;
        w_tail_ctrl.clear = w_in_acc && w_is_reset;
    end

    twma_cell u_cell_head (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctrl  (w_head_ctrl),
        .i_data  (w_head_in),
        .o_data  (w_cell[0])
    );

    for (genvar k = 1; k < WINDOW_SIZE; k++) begin : g_chain
        twma_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_ctrl  (w_tail_ctrl),
            .i_data  (w_cell[k-1]),
            .o_data  (w_cell[k])
        );
    end

    // Sum and index update for the accepted request
    always_comb begin
        w_new_wgt  = WGT_W'(w_new) * N_WGT;
        n_running  = r_running;
        n_weighted = r_weighted;
        n_index    = r_index;
        n_full     = r_full;
        if (w_in_acc) begin
            if (w_is_reset) begin
                n_running  = SUM_W'(w_new);
                n_weighted = w_new_wgt;
                n_index    = (WINDOW_SIZE == 1) ? '0 : IDX_W'(1);
                n_full     = (WINDOW_SIZE == 1);
            end else begin
                // drop the oldest sample, age every weight by one
                n_running  = r_running - SUM_W'(w_cell[WINDOW_SIZE-1]) + SUM_W'(w_new);
                n_weighted = r_weighted - WGT_W'(r_running) + w_new_wgt;
                if (r_index == IDX_LAST) begin
                    n_index = '0;
                    n_full  = 1'b1;
                end else begin
                    n_index = r_index + IDX_W'(1);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_running  <= '0;
            r_weighted <= '0;
            r_index    <= '0;
            r_full     <= 1'b0;
        end else begin
            r_running  <= n_running;
            r_weighted <= n_weighted;
            r_index    <= n_index;
            r_full     <= n_full;
        end
    end

    // Divider: rounded average of the updated weighted sum
    assign w_dividend = DVD_W'(r_weighted) + HALF_W;

    twma_div #(
        .DVD_W   (DVD_W),
        .DIVISOR (TOTAL)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (r_state == S_START),
        .i_dividend (w_dividend),
        .o_done     (w_div_done),
        .o_quotient (w_quotient)
    );

    // Load the output register once the quotient is ready and the slot is free.
    assign w_load = (r_state == S_WAIT) && w_div_done && (!r_m_valid || i_m_axis_tready);

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:  if (w_in_acc) n_state = S_START;
            S_START: n_state = S_WAIT;
            S_WAIT:  if (w_load) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_m_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_load) begin
                r_m_valid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_m_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_m_data[23:0]  <= r_full ? w_quotient : w_cell[0];
            r_m_data[47:24] <= w_cell[0];
            r_m_full        <= r_full;
        end
    end

    assign o_m_axis_tvalid = r_m_valid;
    assign o_m_axis_tdata  = r_m_data;
    assign o_m_axis_tuser  = r_m_full;

endmodule

[sv/twma_cell.sv]
// One cell of the sample chain: holds one 24-bit sample.
// Depends on twma_pkg for the sample width and the cell command struct.
module twma_cell (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  twma_pkg::t_cell_ctrl                i_ctrl,
    input  logic signed [twma_pkg::SAMPLE_W-1:0] i_data,
    output logic signed [twma_pkg::SAMPLE_W-1:0] o_data
);

    logic signed [twma_pkg::SAMPLE_W-1:0] r_sample;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_ctrl.clear) begin
            r_sample <= '0;
        end else if (i_ctrl.shift) begin
            r_sample <= i_data;
        end
    end

    assign o_data = r_sample;

endmodule

[sv/twma_div.sv]
// Division of a signed dividend by a constant divisor, truncating toward zero,
// by reciprocal multiplication over three register stages.
// Depends on twma_pkg for the quotient width.
module twma_div #(
    parameter int DVD_W   = 34,
    parameter int DIVISOR = 136
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_start,
    input  logic signed [DVD_W-1:0]              i_dividend,
    output logic                                 o_done,
    output logic signed [twma_pkg::SAMPLE_W-1:0] o_quotient
);

    localparam int SW    = twma_pkg::SAMPLE_W;
    // With RECIP = ceil(2^SHR / DIVISOR), floor(mag * RECIP / 2^SHR) is the exact
    // floor(mag / DIVISOR) for every magnitude below 2^DVD_W.
    localparam int SHR   = DVD_W + $clog2(DIVISOR);
    localparam int REC_W = DVD_W + 1;
    localparam int LO_W  = REC_W / 2;
    localparam int HI_W  = REC_W - LO_W;
    localparam int PRD_W = DVD_W + REC_W;
    localparam logic [63:0] RECIP64 =
        ((64'd1 << SHR) + 64'(DIVISOR) - 64'd1) / 64'(DIVISOR);
    localparam logic [LO_W-1:0] RECIP_LO = RECIP64[LO_W-1:0];
    localparam logic [HI_W-1:0] RECIP_HI = RECIP64[REC_W-1:LO_W];

    logic [DVD_W-1:0]      r_mag;
    logic                  r_neg;
    logic [DVD_W+LO_W-1:0] r_prod_lo;
    logic [DVD_W+HI_W-1:0] r_prod_hi;
    logic [SW-1:0]         r_qmag;
    logic                  r_stage1;
    logic                  r_stage2;
    logic                  r_done;
    logic [PRD_W-1:0]      w_prod;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stage1 <= 1'b0;
            r_stage2 <= 1'b0;
            r_done   <= 1'b0;
        end else begin
            r_stage1 <= i_start;
            r_stage2 <= r_stage1;
            if (i_start) begin
                r_done <= 1'b0;
            end else if (r_stage2) begin
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            // take the magnitude; the sign is restored on the way out
            r_neg <= i_dividend[DVD_W-1];
            r_mag <= i_dividend[DVD_W-1] ? $unsigned(-i_dividend) : $unsigned(i_dividend);
        end
        if (r_stage1) begin
            r_prod_lo <= (DVD_W+LO_W)'(r_mag) * (DVD_W+LO_W)'(RECIP_LO);
            r_prod_hi <= (DVD_W+HI_W)'(r_mag) * (DVD_W+HI_W)'(RECIP_HI);
        end
        if (r_stage2) begin
            r_qmag <= w_prod[SHR +: SW];
        end
    end

    assign w_prod     = PRD_W'(r_prod_lo) + {r_prod_hi, {LO_W{1'b0}}};
    assign o_quotient = r_neg ? $signed(-r_qmag) : $signed(r_qmag);
    assign o_done     = r_done;

endmodule

[sv/twma_checker.sv]
// Port-level assertions for the triangle-weighted moving average,
// bound to the top level. Depends on triangle_weighted_moving_average.
module twma_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_s_axis_tvalid,
    input logic        o_s_axis_tready,
    input logic        o_m_axis_tvalid,
    input logic        i_m_axis_tready,
    input logic [47:0] o_m_axis_tdata,
    input logic        o_m_axis_tuser
);

    // A stalled result holds its payload.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=>
            o_m_axis_tvalid && $stable(o_m_axis_tdata) && $stable(o_m_axis_tuser))
        else $error("result changed while stalled");

    // One request at a time: ready drops right after a request is taken.
    a_one: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_axis_tvalid && o_s_axis_tready |=> !o_s_axis_tready)
        else $error("request taken while busy");

    // Before the window fills, the filtered value is the raw sample.
    a_raw: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !o_m_axis_tuser |->
            o_m_axis_tdata[23:0] == o_m_axis_tdata[47:24])
        else $error("filtered differs from raw before window full");

    // Reset leaves no result pending.
    a_rst: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_axis_tvalid)
        else $error("result valid after reset");

endmodule

bind triangle_weighted_moving_average twma_checker u_twma_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_s_axis_tvalid (i_s_axis_tvalid),
    .o_s_axis_tready (o_s_axis_tready),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata),
    .o_m_axis_tuser  (o_m_axis_tuser)
);
